### sv/uvs_pkg.sv
// uvs_pkg: shared types, register indexes and constants of the uv sphere mesh generator
// no dependencies; imported by uv_sphere_mesh_generator
package uvs_pkg;

    localparam int DEF_MAX_RINGS       = 64;
    localparam int DEF_MAX_MERIDIANS   = 64;
    localparam int DEF_ANGLE_FRAC_BITS = 16;

    localparam int CORDIC_STEPS = 24;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 16;
    localparam logic [CFG_AW-1:0] CFG_RING_COUNT     = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_MERIDIAN_COUNT = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_HALF_MODE      = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_RADIUS         = 2'd3;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 144;

    localparam logic ITEM_VERTEX = 1'b0;
    localparam logic ITEM_FACE   = 1'b1;

    typedef struct packed {
        logic               last_item;
        logic [12:0]        corner_c;
        logic [12:0]        corner_b;
        logic [12:0]        corner_a;
        logic signed [15:0] norm_z;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_x;
        logic signed [16:0] pos_z;
        logic signed [16:0] pos_y;
        logic signed [16:0] pos_x;
        logic               item_kind;
    } result_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SETUP = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_COR   = 6'b001000,
        ST_MUL   = 6'b010000,
        ST_OUT   = 6'b100000
    } seq_state_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_VERT = 4'b0010,
        PH_FACE = 4'b0100,
        PH_DONE = 4'b1000
    } gen_phase_t;

    // arctangent of 2^-k in 2^-32 turns
    function automatic logic [31:0] atan_turn(input logic [4:0] k);
        logic [31:0] v;
        begin
            unique case (k)
                5'd0:  v = 32'd536870912;
                5'd1:  v = 32'd316933406;
                5'd2:  v = 32'd167458907;
                5'd3:  v = 32'd85004756;
                5'd4:  v = 32'd42667331;
                5'd5:  v = 32'd21354465;
                5'd6:  v = 32'd10679838;
                5'd7:  v = 32'd5340245;
                5'd8:  v = 32'd2670163;
                5'd9:  v = 32'd1335087;
                5'd10: v = 32'd667544;
                5'd11: v = 32'd333772;
                5'd12: v = 32'd166886;
                5'd13: v = 32'd83443;
                5'd14: v = 32'd41722;
                5'd15: v = 32'd20861;
                5'd16: v = 32'd10430;
                5'd17: v = 32'd5215;
                5'd18: v = 32'd2608;
                5'd19: v = 32'd1304;
                5'd20: v = 32'd652;
                5'd21: v = 32'd326;
                5'd22: v = 32'd163;
                5'd23: v = 32'd81;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage

### sv/uv_sphere_mesh_generator.sv
// uv_sphere_mesh_generator: latitude-longitude sphere mesh source, one item per transaction
// depends on uvs_pkg (types, register indexes, cordic table)
//
// Each input transaction asks for the next mesh item; restart=1 latches the configuration and
// emits the top pole. Order: top pole, bottom pole, ring vertices (ring index fastest), then
// triangle faces; after the last face (tlast) nothing more comes until the next restart.
// Poles and faces are built in ST_IDLE on acceptance; ST_OUT then moves the result into the
// output register once that is free; a request with nothing left gives no result and the
// block stays ready. A ring vertex runs on one shared datapath under a small sequencer:
// per angle a setup step, a restoring divide to an NW-bit quotient (NW = ANGLE_FRAC_BITS +
// clog2(2*MAX_MERIDIANS+MAX_RINGS+3) + 1, 25 by default) and 24 cordic rotations, twice,
// then a multiply phase on one 32x32 multiplier before the result goes out through ST_OUT.
// s_tready is high only while the sequencer is idle; a finished result waits in its output
// register without holding up the next request, and the next result waits until it drains.
module uv_sphere_mesh_generator #(
    parameter int MAX_RINGS       = uvs_pkg::DEF_MAX_RINGS,
    parameter int MAX_MERIDIANS   = uvs_pkg::DEF_MAX_MERIDIANS,
    parameter int ANGLE_FRAC_BITS = uvs_pkg::DEF_ANGLE_FRAC_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [uvs_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [uvs_pkg::CFG_DW-1:0]    cfg_wdata,
    // request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [uvs_pkg::S_TDATA_W-1:0] s_tdata,   // [0] restart, [7:1] zero
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [uvs_pkg::M_TDATA_W-1:0] m_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y,
                                                     // norm_z, corner_a, corner_b, corner_c,
                                                     // zero fill
    output logic                          m_tuser,   // item_kind
    output logic                          m_tlast    // last_item
);
    import uvs_pkg::*;

    localparam int F    = ANGLE_FRAC_BITS;
    localparam int RW   = $clog2(MAX_RINGS + 1);
    localparam int MW   = $clog2(MAX_MERIDIANS + 1);
    localparam int FW   = RW + 1;                       // face step, up to 2*rings-1
    localparam int VW   = MW + RW + 1;                  // vertex index arithmetic
    localparam int MAXV = (MAX_RINGS + 2 > MAX_MERIDIANS) ? MAX_RINGS + 2 : MAX_MERIDIANS;
    localparam int DW   = $clog2(2 * MAXV + 1);         // divisor width
    localparam int NW   = F + $clog2(2 * MAX_MERIDIANS + MAX_RINGS + 3) + 1;
    localparam int CW   = ($clog2(NW) > 5) ? $clog2(NW) : 5;

    // configuration registers
    logic [6:0]  ring_req_reg;
    logic [7:0]  mer_req_reg;
    logic        half_mode_reg;
    logic [15:0] radius_reg;

    // control state
    seq_state_t  state_reg, state_next;
    gen_phase_t  phase_reg, phase_next;
    logic [MW-1:0] mi_reg, mi_next;
    logic [RW-1:0] ri_reg, ri_next;
    logic [FW-1:0] fs_reg, fs_next;
    logic [RW-1:0] eff_r_reg, eff_r_next;
    logic [MW-1:0] eff_m_reg, eff_m_next;
    logic        lat_half_reg, lat_half_next;
    logic [15:0] lat_rad_reg, lat_rad_next;
    logic        pass_reg, pass_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic        m_tvalid_reg, m_tvalid_next;

    // datapath registers
    logic [MW-1:0] vi_reg, vi_next;
    logic [RW-1:0] vj_reg, vj_next;
    logic [NW-1:0] div_num_reg, div_num_next;
    logic [DW-1:0] div_rem_reg, div_rem_next;
    logic [DW-1:0] div_den_reg, div_den_next;
    logic signed [33:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [32:0] cz_reg, cz_next;
    logic [1:0]  quad_reg, quad_next;
    logic signed [31:0] c1_reg, c1_next, s1_reg, s1_next, c2_reg, c2_next, s2_reg, s2_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [31:0] u0_reg, u0_next, u2_reg, u2_next;
    logic signed [16:0] px_reg, px_next, py_reg, py_next;
    result_t     res_reg, res_next;
    result_t     out_reg, out_next;

    // request decode
    logic        accept, restart;
    gen_phase_t  cur_phase;
    logic [MW-1:0] cur_mi;
    logic [RW-1:0] cur_ri, cur_r;
    logic [FW-1:0] cur_fs;
    logic [MW-1:0] cur_m;
    logic        cur_half;
    logic [15:0] cur_rad;
    logic [8:0]  rq9, mq9;
    logic [RW:0] ri_inc;
    logic [MW:0] mi_inc;
    logic [FW:0] fs_inc;

    // face corners
    logic [MW-1:0] nxt_mi;
    logic [VW-1:0] v1, v2, fj;
    logic [FW-1:0] fs_m2;

    // divider, cordic and multiplier
    logic [DW:0]   trial;
    logic          ge;
    logic [NW-1:0] quot;
    logic [31:0]   turn;
    logic signed [33:0] sx, sy, nx, ny;
    logic signed [32:0] at;
    logic signed [31:0] cos_q, sin_q;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] rnd;
    logic signed [31:0] rad_s;

    // truncating shift toward zero
    function automatic logic signed [33:0] shr_tz(input logic signed [33:0] v,
                                                  input logic [4:0] k);
        logic signed [33:0] m;
        begin
            m = -v;
            return v[33] ? -(m >>> k) : (v >>> k);
        end
    endfunction

    function automatic logic signed [16:0] clamp_pos(input logic signed [63:0] v);
        begin
            if (v < -64'sd65536) return -17'sd65536;
            else if (v > 64'sd65535) return 17'sd65535;
            else return 17'(v);
        end
    endfunction

    function automatic logic signed [15:0] to_norm(input logic signed [31:0] u);
        logic signed [31:0] t;
        begin
            t = (u + 32'sd32768) >>> 16;
            if (t < -32'sd16384) return -16'sd16384;
            else if (t > 32'sd16384) return 16'sd16384;
            else return 16'(t);
        end
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign restart  = s_tdata[0];

    // effective sizes from the requested counts
    always_comb begin
        rq9 = {2'b00, ring_req_reg};
        if (rq9 == 9'd0) rq9 = 9'd1;
        if (rq9 > 9'(MAX_RINGS)) rq9 = 9'(MAX_RINGS);
        mq9 = half_mode_reg ? {2'b00, mer_req_reg[7:1]} : {1'b0, mer_req_reg};
        if (mq9 < 9'd2) mq9 = 9'd2;
        if (mq9 > 9'(MAX_MERIDIANS)) mq9 = 9'(MAX_MERIDIANS);
    end

    // restart takes effect on the same transaction
    always_comb begin
        cur_phase = restart ? PH_VERT : phase_reg;
        cur_mi    = restart ? '0 : mi_reg;
        cur_ri    = restart ? '0 : ri_reg;
        cur_fs    = restart ? '0 : fs_reg;
        cur_r     = restart ? RW'(rq9) : eff_r_reg;
        cur_m     = restart ? MW'(mq9) : eff_m_reg;
        cur_half  = restart ? half_mode_reg : lat_half_reg;
        cur_rad   = restart ? radius_reg : lat_rad_reg;
        ri_inc    = {1'b0, cur_ri} + 1'b1;
        mi_inc    = {1'b0, cur_mi} + 1'b1;
        fs_inc    = {1'b0, cur_fs} + 1'b1;
    end

    // face corner indices: v1 = 2+i*R, v2 = 2+((i+1) mod M)*R
    always_comb begin
        nxt_mi = (mi_inc >= {1'b0, cur_m}) ? '0 : mi_inc[MW-1:0];
        v1     = VW'(2) + VW'(VW'(cur_mi) * VW'(cur_r));
        v2     = VW'(2) + VW'(VW'(nxt_mi) * VW'(cur_r));
        fs_m2  = cur_fs - FW'(2);
        fj     = VW'(fs_m2 >> 1);
    end

    // shared datapath pieces
    always_comb begin
        trial = {div_rem_reg, div_num_reg[NW-1]};
        ge    = (trial >= {1'b0, div_den_reg});
        quot  = {div_num_reg[NW-2:0], ge};
        turn  = {quot[F-1:0], {(32 - F){1'b0}}};

        sx = shr_tz(cy_reg, cnt_reg[4:0]);
        sy = shr_tz(cx_reg, cnt_reg[4:0]);
        at = 33'(atan_turn(cnt_reg[4:0]));
        if (!cz_reg[32]) begin
            nx = cx_reg - sx;
            ny = cy_reg + sy;
        end else begin
            nx = cx_reg + sx;
            ny = cy_reg - sy;
        end
        unique case (quad_reg)
            2'd0: begin cos_q = 32'(nx);  sin_q = 32'(ny);  end
            2'd1: begin cos_q = -32'(ny); sin_q = 32'(nx);  end
            2'd2: begin cos_q = -32'(nx); sin_q = -32'(ny); end
            default: begin cos_q = 32'(ny); sin_q = -32'(nx); end
        endcase

        rad_s = signed'({16'd0, lat_rad_reg});
        unique case (cnt_reg[2:0])
            3'd0: begin mul_a = s2_reg; mul_b = c1_reg; end
            3'd1: begin mul_a = s2_reg; mul_b = s1_reg; end
            3'd2: begin mul_a = u0_reg; mul_b = rad_s;  end
            3'd3: begin mul_a = c2_reg; mul_b = rad_s;  end
            default: begin mul_a = u2_reg; mul_b = rad_s; end
        endcase
        rnd = (prod_reg + 64'sd536870912) >>> 30;
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        mi_next       = mi_reg;
        ri_next       = ri_reg;
        fs_next       = fs_reg;
        eff_r_next    = eff_r_reg;
        eff_m_next    = eff_m_reg;
        lat_half_next = lat_half_reg;
        lat_rad_next  = lat_rad_reg;
        pass_next     = pass_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        vi_next       = vi_reg;
        vj_next       = vj_reg;
        div_num_next  = div_num_reg;
        div_rem_next  = div_rem_reg;
        div_den_next  = div_den_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        cz_next       = cz_reg;
        quad_next     = quad_reg;
        c1_next       = c1_reg;
        s1_next       = s1_reg;
        c2_next       = c2_reg;
        s2_next       = s2_reg;
        prod_next     = prod_reg;
        u0_next       = u0_reg;
        u2_next       = u2_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        res_next      = res_reg;
        out_next      = out_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (restart) begin
                        eff_r_next    = cur_r;
                        eff_m_next    = cur_m;
                        lat_half_next = cur_half;
                        lat_rad_next  = cur_rad;
                    end
                    phase_next = cur_phase;
                    mi_next    = cur_mi;
                    ri_next    = cur_ri;
                    fs_next    = cur_fs;
                    res_next   = '0;
                    if (cur_phase == PH_VERT) begin
                        res_next.item_kind = ITEM_VERTEX;
                        if (cur_fs < FW'(2)) begin
                            // poles sit on the y axis
                            if (cur_fs == '0) begin
                                res_next.pos_y  = signed'({1'b0, cur_rad});
                                res_next.norm_y = 16'sd16384;
                            end else begin
                                res_next.pos_y  = -signed'({1'b0, cur_rad});
                                res_next.norm_y = -16'sd16384;
                            end
                            fs_next    = fs_inc[FW-1:0];
                            state_next = ST_OUT;
                        end else begin
                            vi_next = cur_mi;
                            vj_next = cur_ri;
                            if (ri_inc >= {1'b0, cur_r}) begin
                                ri_next = '0;
                                if (mi_inc >= {1'b0, cur_m}) begin
                                    phase_next = PH_FACE;
                                    mi_next    = '0;
                                    fs_next    = '0;
                                end else begin
                                    mi_next = mi_inc[MW-1:0];
                                end
                            end else begin
                                ri_next = ri_inc[RW-1:0];
                            end
                            pass_next  = 1'b0;
                            state_next = ST_SETUP;
                        end
                    end else if (cur_phase == PH_FACE) begin
                        res_next.item_kind = ITEM_FACE;
                        if (cur_fs == '0) begin
                            res_next.corner_a = 13'd0;
                            res_next.corner_b = 13'(v1);
                            res_next.corner_c = 13'(v2);
                        end else if (cur_fs == FW'(1)) begin
                            res_next.corner_a = 13'd1;
                            res_next.corner_b = 13'(v2 + VW'(cur_r) - VW'(1));
                            res_next.corner_c = 13'(v1 + VW'(cur_r) - VW'(1));
                        end else if (!fs_m2[0]) begin
                            res_next.corner_a = 13'(v1 + fj);
                            res_next.corner_b = 13'(v1 + fj + VW'(1));
                            res_next.corner_c = 13'(v2 + fj + VW'(1));
                        end else begin
                            res_next.corner_a = 13'(v1 + fj);
                            res_next.corner_b = 13'(v2 + fj + VW'(1));
                            res_next.corner_c = 13'(v2 + fj);
                        end
                        if (fs_inc >= {cur_r, 1'b0}) begin
                            fs_next = '0;
                            if (mi_inc >= {1'b0, cur_m}) begin
                                phase_next         = PH_DONE;
                                mi_next            = mi_inc[MW-1:0];
                                res_next.last_item = 1'b1;
                            end else begin
                                mi_next = mi_inc[MW-1:0];
                            end
                        end else begin
                            fs_next = fs_inc[FW-1:0];
                        end
                        state_next = ST_OUT;
                    end
                end
            end
            ST_SETUP: begin
                // a1 = (2*i*span + (M-1)) / (2*(M-1)), a2 = ((j+1)*S + (R+2)) / (2*(R+2))
                if (!pass_reg) begin
                    div_num_next = (lat_half_reg ? (NW'(vi_reg) << F) : (NW'(vi_reg) << (F + 1)))
                                   + NW'(eff_m_reg) - NW'(1);
                    div_den_next = (DW'(eff_m_reg) - DW'(1)) << 1;
                end else begin
                    div_num_next = ((NW'(vj_reg) + NW'(1)) << F) + NW'(eff_r_reg) + NW'(2);
                    div_den_next = (DW'(eff_r_reg) + DW'(2)) << 1;
                end
                div_rem_next = '0;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                div_num_next = quot;
                div_rem_next = ge ? DW'(trial - {1'b0, div_den_reg}) : DW'(trial);
                if (cnt_reg == CW'(NW - 1)) begin
                    cx_next    = CORDIC_GAIN;
                    cy_next    = '0;
                    cz_next    = signed'({3'b000, turn[29:0]});
                    quad_next  = turn[31:30];
                    cnt_next   = '0;
                    state_next = ST_COR;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_COR: begin
                cx_next = nx;
                cy_next = ny;
                cz_next = cz_reg[32] ? cz_reg + at : cz_reg - at;
                if (cnt_reg == CW'(CORDIC_STEPS - 1)) begin
                    cnt_next = '0;
                    if (!pass_reg) begin
                        c1_next    = cos_q;
                        s1_next    = sin_q;
                        pass_next  = 1'b1;
                        state_next = ST_SETUP;
                    end else begin
                        c2_next    = cos_q;
                        s2_next    = sin_q;
                        state_next = ST_MUL;
                    end
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MUL: begin
                prod_next = mul_a * mul_b;
                cnt_next  = cnt_reg + 1'b1;
                unique case (cnt_reg[2:0])
                    3'd0: ;
                    3'd1: u0_next = 32'(rnd);
                    3'd2: u2_next = 32'(rnd);
                    3'd3: px_next = clamp_pos(rnd);
                    3'd4: py_next = clamp_pos(rnd);
                    default: begin
                        res_next.item_kind = ITEM_VERTEX;
                        res_next.pos_x     = px_reg;
                        res_next.pos_y     = py_reg;
                        res_next.pos_z     = clamp_pos(rnd);
                        if (lat_half_reg && (vi_reg == '0 || vi_reg == eff_m_reg - 1'b1)) begin
                            // flat side of a half sphere
                            res_next.norm_x = '0;
                            res_next.norm_y = '0;
                            res_next.norm_z = -16'sd16384;
                        end else begin
                            res_next.norm_x = to_norm(u0_reg);
                            res_next.norm_y = to_norm(c2_reg);
                            res_next.norm_z = to_norm(u2_reg);
                        end
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_next      = res_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_req_reg  <= 7'd8;
            mer_req_reg   <= 8'd16;
            half_mode_reg <= 1'b0;
            radius_reg    <= 16'd256;
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_IDLE;
            mi_reg        <= '0;
            ri_reg        <= '0;
            fs_reg        <= '0;
            eff_r_reg     <= '0;
            eff_m_reg     <= '0;
            lat_half_reg  <= 1'b0;
            lat_rad_reg   <= '0;
            pass_reg      <= 1'b0;
            cnt_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_RING_COUNT:     ring_req_reg  <= cfg_wdata[6:0];
                    CFG_MERIDIAN_COUNT: mer_req_reg   <= cfg_wdata[7:0];
                    CFG_HALF_MODE:      half_mode_reg <= cfg_wdata[0];
                    CFG_RADIUS:         radius_reg    <= cfg_wdata;
                    default: ;
                endcase
            end
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            mi_reg       <= mi_next;
            ri_reg       <= ri_next;
            fs_reg       <= fs_next;
            eff_r_reg    <= eff_r_next;
            eff_m_reg    <= eff_m_next;
            lat_half_reg <= lat_half_next;
            lat_rad_reg  <= lat_rad_next;
            pass_reg     <= pass_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        vi_reg      <= vi_next;
        vj_reg      <= vj_next;
        div_num_reg <= div_num_next;
        div_rem_reg <= div_rem_next;
        div_den_reg <= div_den_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        cz_reg      <= cz_next;
        quad_reg    <= quad_next;
        c1_reg      <= c1_next;
        s1_reg      <= s1_next;
        c2_reg      <= c2_next;
        s2_reg      <= s2_next;
        prod_reg    <= prod_next;
        u0_reg      <= u0_next;
        u2_reg      <= u2_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    // result channel
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.item_kind;
    assign m_tlast  = out_reg.last_item;
    assign m_tdata  = {6'd0, out_reg.corner_c, out_reg.corner_b, out_reg.corner_a,
                       out_reg.norm_z, out_reg.norm_y, out_reg.norm_x,
                       out_reg.pos_z, out_reg.pos_y, out_reg.pos_x};

`ifndef SYNTH
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) |=>
        (m_tvalid_reg && state_reg == ST_IDLE))
        else $error("finished result not moved to output register");

    a_cordic_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COR) |-> (cnt_reg < CW'(CORDIC_STEPS)))
        else $error("cordic step count overrun");

    a_last_is_face: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && out_reg.last_item) |-> (out_reg.item_kind == ITEM_FACE))
        else $error("last item flagged on a vertex");

    a_ring_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_VERT) |-> (ri_reg < eff_r_reg))
        else $error("ring index beyond ring count");
`endif

endmodule
